// File: rtl/core/ima_adpcm_channel_decoder_defines.svh
// Assertion shorthands shared by the decoder RTL.
`ifndef IMA_ADPCM_CHANNEL_DECODER_DEFINES_SVH
`define IMA_ADPCM_CHANNEL_DECODER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define IMADEC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define IMADEC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/imadec_pkg.sv
package imadec_pkg;

    localparam int STEP_ENTRIES = 89;
    localparam logic [6:0] MAX_INDEX = 7'd88;

    localparam logic signed [15:0] PRED_MAX = 16'sh7FFF;
    localparam logic signed [15:0] PRED_MIN = 16'sh8000;

    // Per-channel decoder state as held in the channel memory
    typedef struct packed {
        logic signed [15:0] pred;
        logic [6:0]         idx;
    } state_t;

    localparam logic [14:0] STEP_ROM [STEP_ENTRIES] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,
        15'd13,    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,
        15'd23,    15'd25,    15'd28,    15'd31,    15'd34,    15'd37,
        15'd41,    15'd45,    15'd50,    15'd55,    15'd60,    15'd66,
        15'd73,    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
        15'd130,   15'd143,   15'd157,   15'd173,   15'd190,   15'd209,
        15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
        15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,
        15'd724,   15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,
        15'd1282,  15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
        15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,  15'd3660,
        15'd4026,  15'd4428,  15'd4871,  15'd5358,  15'd5894,  15'd6484,
        15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442, 15'd11487,
        15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
        15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    localparam logic signed [4:0] ADJUST_ROM [8] = '{
        -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
    };

    // Indexes above the table clamp to its last entry
    function automatic logic [14:0] step_lookup(input logic [6:0] idx);
        logic [14:0] step;
        if (idx > MAX_INDEX)
        begin
            step = STEP_ROM[MAX_INDEX];
        end
        else
        begin
            step = STEP_ROM[idx];
        end
        return step;
    endfunction

endpackage

// File: rtl/core/imadec_nibble.sv
module imadec_nibble
    import imadec_pkg::*;
(
    input  state_t     state_in,
    input  logic [3:0] code,
    output state_t     state_out
);

    logic [14:0]        step;
    logic [15:0]        diff;
    logic signed [17:0] base;
    logic signed [17:0] sum;
    logic signed [4:0]  adj;
    logic signed [7:0]  idx_sum;

    always_comb
    begin
        step = step_lookup(state_in.idx);
        diff = {4'b0, step[14:3]}
             + (code[0] ? {3'b0, step[14:2]} : 16'd0)
             + (code[1] ? {2'b0, step[14:1]} : 16'd0)
             + (code[2] ? {1'b0, step}       : 16'd0);

        base = {{2{state_in.pred[15]}}, state_in.pred};
        if (code[3])
        begin
            sum = base + $signed({2'b00, diff});
        end
        else
        begin
            sum = base - $signed({2'b00, diff});
        end

        // saturate toward the side the difference moved
        priority if (code[3] && (sum > 18'sd32767))
        begin
            state_out.pred = PRED_MAX;
        end
        else if (!code[3] && (sum < -18'sd32768))
        begin
            state_out.pred = PRED_MIN;
        end
        else
        begin
            state_out.pred = sum[15:0];
        end

        adj     = ADJUST_ROM[code[2:0]];
        idx_sum = $signed({1'b0, state_in.idx}) + {{3{adj[4]}}, adj};
        priority if (idx_sum[7])
        begin
            state_out.idx = 7'd0;
        end
        else if (idx_sum > $signed({1'b0, MAX_INDEX}))
        begin
            state_out.idx = MAX_INDEX;
        end
        else
        begin
            state_out.idx = idx_sum[6:0];
        end
    end

endmodule

// File: rtl/core/ima_adpcm_channel_decoder.sv
// Channel   Direction  Handshake          Beat contents
// input     in         in_valid/in_stall  channel, code_byte, low_nibble_only, restart
// output    out        out_valid/out_stall out_channel, sample, step_index_after,
//                                         last_of_byte
//
// Decode: a byte beat holds the decode stage for its low nibble, then its high nibble,
// or for its low nibble only with low_nibble_only; the single nibble decoder serves both.
// An input beat is registered into the decode stage, and its samples into the output register.
// Reset clears all channels at once through per-channel valid bits; no sweep.
// A stalled output holds the decode stage, which in turn stalls the input.
// Beats for a channel at or above NUM_CHANNELS are taken and dropped.
`include "ima_adpcm_channel_decoder_defines.svh"

module ima_adpcm_channel_decoder
    import imadec_pkg::*;
#(
    parameter int NUM_CHANNELS = 16
)(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         channel,
    input  logic [7:0]         code_byte,
    input  logic               low_nibble_only,
    input  logic               restart,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         out_channel,
    output logic signed [15:0] sample,
    output logic [6:0]         step_index_after,
    output logic               last_of_byte
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Channel state memory: read on input beat, written when a byte finishes
    state_t mem [NUM_CHANNELS];
    state_t rd_state_reg;
    logic [NUM_CHANNELS-1:0] ent_vld_reg;

    // Decode stage
    logic       st_vld_reg;
    logic       st_phase_reg;
    logic [3:0] st_ch_reg;
    logic [7:0] st_byte_reg;
    logic       st_lno_reg;
    logic       st_rst_reg;
    state_t     work_reg;

    // Last written channel, forwarded over the memory's read-before-write
    logic          last_vld_reg;
    logic [AW-1:0] last_addr_reg;
    state_t        last_state_reg;

    // Output register
    logic               out_vld_reg;
    logic [3:0]         out_ch_reg;
    logic signed [15:0] out_sample_reg;
    logic [6:0]         out_idx_reg;
    logic               out_last_reg;

    logic          in_acc;
    logic          in_range;
    logic [AW-1:0] in_addr;
    logic [AW-1:0] st_addr;
    logic          adv;
    logic          finish;
    logic          last_nib;
    logic [3:0]    code;
    state_t        cur_state;
    state_t        new_state;

    assign in_range = (32'(channel) < NUM_CHANNELS);
    assign in_addr  = AW'(channel);
    assign st_addr  = AW'(st_ch_reg);

    // The stage moves when the output register is free or emptying
    assign adv      = st_vld_reg && (!out_vld_reg || !out_stall);
    assign last_nib = st_phase_reg || st_lno_reg;
    assign finish   = adv && last_nib;
    assign in_stall = st_vld_reg && !finish;
    assign in_acc   = in_valid && !in_stall;

    assign code = st_phase_reg ? st_byte_reg[7:4] : st_byte_reg[3:0];

    // Pick the state the current nibble starts from: channel state for low, working state for high
    always_comb
    begin
        priority if (st_phase_reg)
        begin
            cur_state = work_reg;
        end
        else if (st_rst_reg)
        begin
            cur_state = '0;
        end
        else if (last_vld_reg && (last_addr_reg == st_addr))
        begin
            cur_state = last_state_reg;
        end
        else if (ent_vld_reg[st_addr])
        begin
            cur_state = rd_state_reg;
        end
        else
        begin
            cur_state = '0;
        end
    end

    imadec_nibble u_nibble
    (
        .state_in  (cur_state),
        .code      (code),
        .state_out (new_state)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_vld_reg   <= 1'b0;
            st_phase_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            last_vld_reg <= 1'b0;
            ent_vld_reg  <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                st_vld_reg   <= in_range;
                st_phase_reg <= 1'b0;
            end
            else if (finish)
            begin
                st_vld_reg <= 1'b0;
            end
            else if (adv)
            begin
                st_phase_reg <= 1'b1;
            end

            if (adv)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end

            if (finish)
            begin
                last_vld_reg         <= 1'b1;
                ent_vld_reg[st_addr] <= 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            st_ch_reg   <= channel;
            st_byte_reg <= code_byte;
            st_lno_reg  <= low_nibble_only;
            st_rst_reg  <= restart;
        end
        if (adv && !last_nib)
        begin
            work_reg <= new_state;
        end
        if (finish)
        begin
            last_addr_reg  <= st_addr;
            last_state_reg <= new_state;
        end
        if (adv)
        begin
            out_ch_reg     <= st_ch_reg;
            out_sample_reg <= new_state.pred;
            out_idx_reg    <= new_state.idx;
            out_last_reg   <= last_nib;
        end
    end

    // Channel memory
    always_ff @(posedge clk)
    begin
        if (in_acc && in_range)
        begin
            rd_state_reg <= mem[in_addr];
        end
        if (finish)
        begin
            mem[st_addr] <= new_state;
        end
    end

    assign out_valid        = out_vld_reg;
    assign out_channel      = out_ch_reg;
    assign sample           = out_sample_reg;
    assign step_index_after = out_idx_reg;
    assign last_of_byte     = out_last_reg;

    `IMADEC_ASSERT_NOW(a_idx_range, clk, rst_n, out_vld_reg,
        out_idx_reg <= MAX_INDEX, "step index out of range")
    `IMADEC_ASSERT_NOW(a_phase_pair, clk, rst_n, st_vld_reg && st_phase_reg,
        !st_lno_reg, "high nibble on single-nibble beat")
    `IMADEC_ASSERT_NEXT(a_high_follows, clk, rst_n, adv && !last_nib,
        st_vld_reg && st_phase_reg, "high nibble lost")
    `IMADEC_ASSERT_NEXT(a_last_mark, clk, rst_n, finish,
        out_vld_reg && out_last_reg, "final sample not marked")

endmodule
